// ===== hw/rtl/gcd_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, arctangent table and helpers for the great-circle distance pipeline
package gcd_pkg;

  localparam int CordicStages = 24;
  localparam int TableLen     = 40;
  localparam int NumIter      = (CordicStages > TableLen) ? TableLen : CordicStages;
  localparam int CordicWidth  = 34;

  localparam logic [30:0] Q30One      = 31'h4000_0000;
  localparam logic [31:0] CordicStart = 32'd652032874;
  localparam logic [31:0] PiQ230      = 32'd3373259426;
  localparam logic [32:0] RadiusReset = 33'd6372797561;

  localparam logic signed [30:0] LatLimit = 31'sd900000000;
  localparam logic signed [31:0] LonLimit = 32'sd1800000000;

  localparam logic [22:0] BamDivisor = 23'd7031250;
  localparam logic [21:0] BamBias    = 22'd3515625;
  localparam logic [9:0]  MmPerMeter = 10'd1000;

  function automatic logic [29:0] atan_units(input int idx);
    logic [29:0] r;
    case (idx)
      0:  r = 30'd536870912;
      1:  r = 30'd316933406;
      2:  r = 30'd167458907;
      3:  r = 30'd85004756;
      4:  r = 30'd42667331;
      5:  r = 30'd21354465;
      6:  r = 30'd10679838;
      7:  r = 30'd5340245;
      8:  r = 30'd2670163;
      9:  r = 30'd1335087;
      10: r = 30'd667544;
      11: r = 30'd333772;
      12: r = 30'd166886;
      13: r = 30'd83443;
      14: r = 30'd41722;
      15: r = 30'd20861;
      16: r = 30'd10430;
      17: r = 30'd5215;
      18: r = 30'd2608;
      19: r = 30'd1304;
      20: r = 30'd652;
      21: r = 30'd326;
      22: r = 30'd163;
      23: r = 30'd81;
      24: r = 30'd41;
      25: r = 30'd20;
      26: r = 30'd10;
      27: r = 30'd5;
      28: r = 30'd3;
      29: r = 30'd1;
      30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic [30:0] clamp_q30(input logic signed [CordicWidth-1:0] v);
    logic [30:0] r;
    if (v[CordicWidth-1]) begin
      r = '0;
    end else if (v > $signed({{(CordicWidth-31){1'b0}}, Q30One})) begin
      r = Q30One;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/great_circle_distance_haversine.sv =====
`timescale 1ns / 1ps
// great-circle distance by the haversine formula: top level, product stages and output buffer
//
// takes one position pair per cycle while in_stall_o is low and returns the arc in q2.30
// radians and the distance in whole meters, in request order; the pipeline is
// 2*CordicStages + 57 register stages deep (105 at the default of 24), set by the two
// cordic pipelines and the 32-step square root. the edge that accepts a request loads the
// first stage, and the result reaches the output through the output buffer. a
// two-entry output buffer holds finished results, so requests keep flowing while one result
// waits; the whole pipeline halts only when both entries are full. the radius register is
// read near the end of the pipeline, so write it only while no request is in flight.
module great_circle_distance_haversine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [32:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [30:0] start_latitude_i,
  input  logic signed [31:0] start_longitude_i,
  input  logic signed [30:0] end_latitude_i,
  input  logic signed [31:0] end_longitude_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        central_angle_o,
  output logic [24:0]        distance_meters_o
);
  import gcd_pkg::*;

  localparam logic [1:0] FifoDepth = 2'd2;

  function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = {31'd0, a} * {31'd0, b} + (62'd1 << 29);
    return p[60:30];
  endfunction

  function automatic logic signed [30:0] clamp_lat(input logic signed [30:0] v);
    logic signed [30:0] r;
    if (v > LatLimit) begin
      r = LatLimit;
    end else if (v < -LatLimit) begin
      r = -LatLimit;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_lon(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v > LonLimit) begin
      r = LonLimit;
    end else if (v < -LonLimit) begin
      r = -LonLimit;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic        adv;
  logic [32:0] radius_q;

  // input and clamp
  logic               v0_q;
  logic signed [30:0] lat1_q, lat2_q;
  logic signed [31:0] lon1_q, lon2_q;

  // differences
  logic               v1_q;
  logic [31:0]        dlat_q, dlon_q, x1_q, x2_q;
  logic signed [32:0] dlat, dlon;
  logic [32:0]        adlat, adlon;
  logic [30:0]        alat1, alat2;

  // binary angles
  logic        div_valid;
  logic [31:0] hl, hn, b1, b2, hn_fold;

  // sine and cosine
  logic        rot_valid;
  logic [30:0] s_lat, s_lon, c1, c2;

  // products
  logic        m1_v_q, m2_v_q, m3_v_q;
  logic [30:0] sqlat1_q, c12_q, sqlon_q, sqlat2_q, prod_q, h_q, rest_q;
  logic [31:0] hsum;

  // roots and arc
  logic        root_valid;
  logic [30:0] root_h, root_rest;
  logic        vec_valid;
  logic [31:0] cbam;

  logic        dist_valid;
  logic [31:0] angle;
  logic [24:0] meters;

  // output buffer
  logic [31:0] ent_angle_q [2];
  logic [24:0] ent_dist_q  [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  assign adv        = (cnt_q != FifoDepth);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lat1_q <= clamp_lat(start_latitude_i);
      lon1_q <= clamp_lon(start_longitude_i);
      lat2_q <= clamp_lat(end_latitude_i);
      lon2_q <= clamp_lon(end_longitude_i);
    end
  end

  assign dlat  = {{2{lat1_q[30]}}, lat1_q} - {{2{lat2_q[30]}}, lat2_q};
  assign dlon  = {lon1_q[31], lon1_q} - {lon2_q[31], lon2_q};
  assign adlat = dlat[32] ? 33'(-dlat) : 33'(dlat);
  assign adlon = dlon[32] ? 33'(-dlon) : 33'(dlon);
  assign alat1 = lat1_q[30] ? 31'(-lat1_q) : 31'(lat1_q);
  assign alat2 = lat2_q[30] ? 31'(-lat2_q) : 31'(lat2_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dlat_q <= adlat[31:0];
      dlon_q <= adlon[31:0];
      x1_q   <= {1'b0, alat1[29:0], 1'b0};
      x2_q   <= {1'b0, alat2[29:0], 1'b0};
    end
  end

  gcd_bam_div u_div_hl (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(v1_q), .x_i(dlat_q),
    .valid_o(div_valid), .quo_o(hl)
  );
  gcd_bam_div u_div_hn (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(v1_q), .x_i(dlon_q),
    .valid_o(), .quo_o(hn)
  );
  gcd_bam_div u_div_b1 (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(v1_q), .x_i(x1_q),
    .valid_o(), .quo_o(b1)
  );
  gcd_bam_div u_div_b2 (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(v1_q), .x_i(x2_q),
    .valid_o(), .quo_o(b2)
  );

  // longitude gap past half a turn wraps around the globe
  assign hn_fold = (hn > {1'b0, Q30One}) ? (32'h8000_0000 - hn) : hn;

  gcd_cordic_rot u_rot_lat (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(div_valid), .z_i(hl[30:0]),
    .valid_o(rot_valid), .sin_o(s_lat), .cos_o()
  );
  gcd_cordic_rot u_rot_lon (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(div_valid), .z_i(hn_fold[30:0]),
    .valid_o(), .sin_o(s_lon), .cos_o()
  );
  gcd_cordic_rot u_rot_c1 (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(div_valid), .z_i(b1[30:0]),
    .valid_o(), .sin_o(), .cos_o(c1)
  );
  gcd_cordic_rot u_rot_c2 (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(div_valid), .z_i(b2[30:0]),
    .valid_o(), .sin_o(), .cos_o(c2)
  );

  assign hsum = {1'b0, sqlat2_q} + {1'b0, prod_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqlat1_q <= mul_q30(s_lat, s_lat);
      c12_q    <= mul_q30(c1, c2);
      sqlon_q  <= mul_q30(s_lon, s_lon);
      sqlat2_q <= sqlat1_q;
      prod_q   <= mul_q30(c12_q, sqlon_q);
      if (hsum > {1'b0, Q30One}) begin
        h_q    <= Q30One;
        rest_q <= '0;
      end else begin
        h_q    <= hsum[30:0];
        rest_q <= Q30One - hsum[30:0];
      end
    end
  end

  gcd_isqrt u_sqrt_h (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(m3_v_q), .v_i({h_q, 30'd0}),
    .valid_o(root_valid), .root_o(root_h)
  );
  gcd_isqrt u_sqrt_rest (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(m3_v_q), .v_i({rest_q, 30'd0}),
    .valid_o(), .root_o(root_rest)
  );

  gcd_cordic_vec u_vec (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(root_valid), .x_i(root_rest), .y_i(root_h),
    .valid_o(vec_valid), .cbam_o(cbam)
  );

  gcd_dist u_dist (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(vec_valid), .cbam_i(cbam), .radius_i(radius_q),
    .valid_o(dist_valid), .angle_o(angle), .dist_o(meters)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
    end else if (adv) begin
      v0_q   <= in_valid_i;
      v1_q   <= v0_q;
      m1_v_q <= rot_valid;
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
    end
  end

  assign push = dist_valid && adv;
  assign pop  = (cnt_q != 2'd0) && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_angle_q[wr_q] <= angle;
      ent_dist_q[wr_q]  <= meters;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign out_valid_o       = (cnt_q != 2'd0);
  assign central_angle_o   = ent_angle_q[rd_q];
  assign distance_meters_o = ent_dist_q[rd_q];

endmodule

// ===== hw/rtl/gcd_bam_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider that turns 1e-7 degree values into binary angle units
module gcd_bam_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [31:0] x_i,
  output logic        valid_o,
  output logic [31:0] quo_o
);
  import gcd_pkg::*;

  localparam int Steps   = 8;
  localparam int BitsPer = 4;

  logic [Steps-1:0] valid_q;
  logic [22:0]      rem_q [Steps];
  logic [31:0]      low_q [Steps];
  logic [31:0]      quo_q [Steps];
  logic [53:0]      num;

  assign num = {x_i, 22'd0} + {32'd0, BamBias};

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [22:0] rem_in, rem_d;
    logic [31:0] low_in, low_d, quo_in, quo_d;

    if (s == 0) begin : g_first
      assign rem_in = {1'b0, num[53:32]};
      assign low_in = num[31:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      logic [23:0] trial;
      trial = '0;
      rem_d = rem_in;
      low_d = low_in;
      quo_d = quo_in;
      for (int b = 0; b < BitsPer; b++) begin
        trial = {rem_d, low_d[31]};
        low_d = {low_d[30:0], 1'b0};
        if (trial >= {1'b0, BamDivisor}) begin
          trial = trial - {1'b0, BamDivisor};
          quo_d = {quo_d[30:0], 1'b1};
        end else begin
          quo_d = {quo_d[30:0], 1'b0};
        end
        rem_d = trial[22:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s] <= rem_d;
        low_q[s] <= low_d;
        quo_q[s] <= quo_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[Steps-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign quo_o   = quo_q[Steps-1];

endmodule

// ===== hw/rtl/gcd_cordic_rot.sv =====
`timescale 1ns / 1ps
// rotation-mode cordic pipeline giving clamped q30 sine and cosine
module gcd_cordic_rot (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [30:0] z_i,
  output logic        valid_o,
  output logic [30:0] sin_o,
  output logic [30:0] cos_o
);
  import gcd_pkg::*;

  localparam int W = CordicWidth;

  logic [NumIter:0]      valid_q;
  logic signed [W-1:0]   x_q [NumIter];
  logic signed [W-1:0]   y_q [NumIter];
  logic signed [W-1:0]   z_q [NumIter];
  logic [30:0]           sin_q, cos_q;

  for (genvar i = 0; i < NumIter; i++) begin : g_iter
    logic signed [W-1:0] x_in, y_in, z_in, x_d, y_d, z_d, at;

    assign at = $signed({{(W-30){1'b0}}, atan_units(i)});

    if (i == 0) begin : g_first
      assign x_in = $signed({{(W-32){1'b0}}, CordicStart});
      assign y_in = '0;
      assign z_in = $signed({{(W-31){1'b0}}, z_i});
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    always_comb begin
      if (!z_in[W-1]) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - at;
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + at;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sin_q <= clamp_q30(y_q[NumIter-1]);
      cos_q <= clamp_q30(x_q[NumIter-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[NumIter-1:0], valid_i};
    end
  end

  assign valid_o = valid_q[NumIter];
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

// ===== hw/rtl/gcd_isqrt.sv =====
`timescale 1ns / 1ps
// pipelined bit-pair integer square root, one result bit per stage
module gcd_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [60:0] v_i,
  output logic        valid_o,
  output logic [30:0] root_o
);
  localparam int Steps = 32;

  logic [Steps-1:0] valid_q;
  logic [63:0]      v_q   [Steps];
  logic [63:0]      res_q [Steps];

  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * j);
    logic [63:0] v_in, res_in, v_d, res_d, trial;

    if (j == 0) begin : g_first
      assign v_in   = {3'd0, v_i};
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign res_in = res_q[j-1];
    end

    assign trial = res_in + Bit;

    always_comb begin
      if (v_in >= trial) begin
        v_d   = v_in - trial;
        res_d = (res_in >> 1) + Bit;
      end else begin
        v_d   = v_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        v_q[j]   <= v_d;
        res_q[j] <= res_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[Steps-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign root_o  = res_q[Steps-1][30:0];

endmodule

// ===== hw/rtl/gcd_cordic_vec.sv =====
`timescale 1ns / 1ps
// vectoring-mode cordic pipeline giving the doubled arc in binary angle units
module gcd_cordic_vec (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [30:0] x_i,
  input  logic [30:0] y_i,
  output logic        valid_o,
  output logic [31:0] cbam_o
);
  import gcd_pkg::*;

  localparam int W = CordicWidth;

  logic [NumIter:0]    valid_q;
  logic signed [W-1:0] x_q [NumIter];
  logic signed [W-1:0] y_q [NumIter];
  logic signed [W-1:0] z_q [NumIter];
  logic [31:0]         cbam_q;

  for (genvar i = 0; i < NumIter; i++) begin : g_iter
    logic signed [W-1:0] x_in, y_in, z_in, x_d, y_d, z_d, at;

    assign at = $signed({{(W-30){1'b0}}, atan_units(i)});

    if (i == 0) begin : g_first
      assign x_in = $signed({{(W-31){1'b0}}, x_i});
      assign y_in = $signed({{(W-31){1'b0}}, y_i});
      assign z_in = '0;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    always_comb begin
      if (!y_in[W-1]) begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + at;
      end else begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - at;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cbam_q <= {clamp_q30(z_q[NumIter-1]), 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[NumIter-1:0], valid_i};
    end
  end

  assign valid_o = valid_q[NumIter];
  assign cbam_o  = cbam_q;

endmodule

// ===== hw/rtl/gcd_dist.sv =====
`timescale 1ns / 1ps
// radian conversion, radius scaling and pipelined divide down to whole meters
module gcd_dist (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [31:0] cbam_i,
  input  logic [32:0] radius_i,
  output logic        valid_o,
  output logic [31:0] angle_o,
  output logic [24:0] dist_o
);
  import gcd_pkg::*;

  localparam int Steps   = 7;
  localparam int BitsPer = 4;
  localparam int Lat     = 3 + Steps;

  logic [Lat-1:0] valid_q;
  logic [63:0]    rad_prod, plo_q;
  logic [31:0]    ang1_q, ang2_q, ang3_q;
  logic           rhi_q;
  logic [64:0]    full_prod;
  logic [35:0]    num_q;

  logic [9:0]     rem_q [Steps];
  logic [27:0]    low_q [Steps];
  logic [27:0]    quo_q [Steps];
  logic [31:0]    ang_q [Steps];

  assign rad_prod  = {32'd0, cbam_i} * {32'd0, PiQ230} + 64'h4000_0000;
  assign full_prod = {1'b0, plo_q} + (rhi_q ? {1'b0, ang2_q, 32'd0} : 65'd0);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ang1_q <= rad_prod[62:31];
      plo_q  <= {32'd0, ang1_q} * {32'd0, radius_i[31:0]};
      ang2_q <= ang1_q;
      rhi_q  <= radius_i[32];
      num_q  <= {1'b0, full_prod[64:30]} + 36'd500;
      ang3_q <= ang2_q;
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [9:0]  rem_in, rem_d;
    logic [27:0] low_in, low_d, quo_in, quo_d;
    logic [31:0] ang_in;

    if (s == 0) begin : g_first
      assign rem_in = {2'b0, num_q[35:28]};
      assign low_in = num_q[27:0];
      assign quo_in = '0;
      assign ang_in = ang3_q;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign ang_in = ang_q[s-1];
    end

    always_comb begin
      logic [10:0] trial;
      trial = '0;
      rem_d = rem_in;
      low_d = low_in;
      quo_d = quo_in;
      for (int b = 0; b < BitsPer; b++) begin
        trial = {rem_d, low_d[27]};
        low_d = {low_d[26:0], 1'b0};
        if (trial >= {1'b0, MmPerMeter}) begin
          trial = trial - {1'b0, MmPerMeter};
          quo_d = {quo_d[26:0], 1'b1};
        end else begin
          quo_d = {quo_d[26:0], 1'b0};
        end
        rem_d = trial[9:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s] <= rem_d;
        low_q[s] <= low_d;
        quo_q[s] <= quo_d;
        ang_q[s] <= ang_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[Lat-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[Lat-1];
  assign angle_o = ang_q[Steps-1];
  assign dist_o  = quo_q[Steps-1][24:0];

endmodule

// ===== hw/rtl/gcd_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the great-circle distance block and their binding
module gcd_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] central_angle_o,
  input logic [24:0] distance_meters_o
);
  import gcd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(central_angle_o))
    else $error("stalled result dropped or changed");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> central_angle_o <= PiQ230)
    else $error("central angle above pi");

  a_zero_arc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && central_angle_o == 32'd0 |-> distance_meters_o == 25'd0)
    else $error("nonzero distance for zero arc");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled with empty output buffer");

endmodule

bind great_circle_distance_haversine gcd_port_checks u_gcd_port_checks (.*);

// ===== tb/gcd_checker.sv =====
`timescale 1ns / 1ps
// checker: predicts arc and distance for each accepted request and compares results in order
module gcd_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [32:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [30:0] start_latitude_i,
  input  logic signed [31:0] start_longitude_i,
  input  logic signed [30:0] end_latitude_i,
  input  logic signed [31:0] end_longitude_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [31:0]        central_angle_i,
  input  logic [24:0]        distance_meters_i,
  output int                 n_pending_o,
  output int                 n_errors_o
);
  import gcd_pkg::*;

  typedef struct packed {
    logic [31:0] angle;
    logic [24:0] meters;
  } arc_t;

  localparam longint unsigned One = 64'd1 << 30;

  localparam longint AtanTab [40] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  arc_t        arc_q[$];
  logic [32:0] radius_mm;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void rotate(input longint z, output longint unsigned s,
                                 output longint unsigned c);
    longint x, y, xn;
    x = CordicStart;
    y = 0;
    for (int i = 0; i < NumIter; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - AtanTab[i];
      end else begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + AtanTab[i];
      end
      x = xn;
    end
    s = clip(y, 0, One);
    c = clip(x, 0, One);
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, xn;
    z = 0;
    for (int i = 0; i < NumIter; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + AtanTab[i];
      end else begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - AtanTab[i];
      end
      x = xn;
    end
    return clip(z, 0, One);
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic arc_t predict_arc(longint la1, longint lo1, longint la2,
                                       longint lo2, logic [32:0] rad);
    longint unsigned hl, hn, b1, b2, s_lat, s_lon, c1, c2, dummy, h, rh, rr, bam, ang;
    logic [127:0] prod;
    arc_t r;
    la1 = clip(la1, -900000000, 900000000);
    la2 = clip(la2, -900000000, 900000000);
    lo1 = clip(lo1, -1800000000, 1800000000);
    lo2 = clip(lo2, -1800000000, 1800000000);
    hl = ((mag(la1 - la2) << 32) + 64'd3600000000) / 64'd7200000000;
    hn = ((mag(lo1 - lo2) << 32) + 64'd3600000000) / 64'd7200000000;
    if (hn > One) hn = (64'd1 << 31) - hn;
    b1 = ((mag(la1) << 32) + 64'd1800000000) / 64'd3600000000;
    b2 = ((mag(la2) << 32) + 64'd1800000000) / 64'd3600000000;
    rotate(hl, s_lat, dummy);
    rotate(hn, s_lon, dummy);
    rotate(b1, dummy, c1);
    rotate(b2, dummy, c2);
    h = qmul(s_lat, s_lat) + qmul(qmul(c1, c2), qmul(s_lon, s_lon));
    if (h > One) h = One;
    rh  = int_root(h << 30);
    rr  = int_root((One - h) << 30);
    bam = 2 * vector_angle(rr, rh);
    ang = (bam * 64'd3373259426 + (64'd1 << 30)) >> 31;
    prod = 128'(ang[31:0]) * 128'(rad) + (128'd500 << 30);
    prod = (prod >> 20) / 128'd1024000;
    r.angle  = ang[31:0];
    r.meters = prod[24:0];
    return r;
  endfunction

  assign n_pending_o = arc_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    arc_t want;
    int   errs;
    errs = 0;
    if (!rst_ni) begin
      radius_mm  <= RadiusReset;
      n_errors_o <= 0;
      arc_q.delete();
    end else begin
      if (cfg_we_i) radius_mm <= cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        arc_q = {arc_q, predict_arc(start_latitude_i, start_longitude_i,
                                    end_latitude_i, end_longitude_i, radius_mm)};
      if (out_valid_i && !out_stall_i) begin
        if (arc_q.size() == 0) begin
          $error("result with no request pending: angle %0d meters %0d",
                 central_angle_i, distance_meters_i);
          errs = errs + 1;
        end else begin
          want = arc_q.pop_front();
          if (want.angle !== central_angle_i) begin
            $error("central_angle expected %0d actual %0d", want.angle, central_angle_i);
            errs = errs + 1;
          end
          if (want.meters !== distance_meters_i) begin
            $error("distance_meters expected %0d actual %0d", want.meters,
                   distance_meters_i);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0) n_errors_o <= n_errors_o + errs;
    end
  end
endmodule

// ===== tb/tb_great_circle_distance_haversine.sv =====
`timescale 1ns / 1ps
// testbench top: position pair stimulus, radius settings and verdict
module tb_great_circle_distance_haversine;
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [32:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [30:0] start_latitude_i = '0;
  logic signed [31:0] start_longitude_i = '0;
  logic signed [30:0] end_latitude_i = '0;
  logic signed [31:0] end_longitude_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [31:0]        central_angle_o;
  logic [24:0]        distance_meters_o;
  int                 n_pending, n_errors;
  bit                 steady = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  great_circle_distance_haversine u_top (.*);

  gcd_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_stall_i(in_stall_o), .start_latitude_i, .start_longitude_i,
    .end_latitude_i, .end_longitude_i, .out_valid_i(out_valid_o), .out_stall_i,
    .central_angle_i(central_angle_o), .distance_meters_i(distance_meters_o),
    .n_pending_o(n_pending), .n_errors_o(n_errors)
  );

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 12);
  end

  task automatic send_pair(longint la1, longint lo1, longint la2, longint lo2);
    while (!steady && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    start_latitude_i  <= la1[30:0];
    start_longitude_i <= lo1[31:0];
    end_latitude_i    <= la2[30:0];
    end_longitude_i   <= lo2[31:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic longint rand_lat();
    return longint'($urandom_range(1800000000)) - 900000000;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(32'd3600000000)) - 1800000000;
  endfunction

  task automatic random_pairs(int n);
    longint d;
    for (int i = 0; i < n; i++) begin
      steady = (i >= n / 2) && (i < n / 2 + 60);
      case ($urandom_range(9))
        0: send_pair(longint'($signed($urandom()) >>> 1), longint'($signed($urandom())),
                     longint'($signed($urandom()) >>> 1), longint'($signed($urandom())));
        1, 2: begin
          d = longint'($urandom_range(20000)) - 10000;
          send_pair(rand_lat(), rand_lon(), rand_lat() / 1000 + d, rand_lon() + d);
        end
        default: send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
      endcase
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;
  endtask

  task automatic set_radius(logic [32:0] mm);
    while (n_pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mm;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // same point, poles, antipodes, dateline wrap, clamps
    send_pair(0, 0, 0, 0);
    send_pair(900000000, 0, -900000000, 0);
    send_pair(0, 0, 0, 1800000000);
    send_pair(0, -1800000000, 0, 1800000000);
    send_pair(0, -1000000000, 0, 1000000000);
    send_pair(100000000, -1799999999, -100000000, 1799999999);
    send_pair(1073741823, 2147483647, -1073741824, -2147483648);
    send_pair(-1073741824, -2147483648, 1073741823, 2147483647);
    send_pair(1073741823, 0, 900000000, 0);
    send_pair(515000000, -1270000, 488566000, 23522000);
    send_pair(361200000, -867670000, 339400000, -1184000000);
    send_pair(0, 0, 1, 1);
    send_pair(899999999, 1234567, 899999999, -1798765432);
    send_pair(-450000000, 900000000, 450000000, -900000000);
    send_pair(123456789, 987654321, 123456789, 987654321);
    in_valid_i <= 1'b0;
    random_pairs(150);
    set_radius(33'd1);
    random_pairs(80);
    set_radius(33'h1_FFFF_FFFF);
    send_pair(900000000, 0, -900000000, 0);
    send_pair(0, 0, 0, 1800000000);
    random_pairs(100);
    set_radius(33'd0);
    random_pairs(60);
    set_radius({$urandom(), 1'($urandom())});
    random_pairs(120);
    set_radius(33'd6372797561);
    random_pairs(120);
    while (n_pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
